// ===== rtl/tsde_pkg.sv =====
// ----------------------------------------------------------------------------
// tsde_pkg: shared types and constants for the Thumb subset executor
// Instruction kinds, decode bundle and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package tsde_pkg;

  localparam int unsigned INSTR_W = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REG_AW  = 4;
  localparam int unsigned NUM_REGS_C = 16;
  localparam logic [REG_AW-1:0] SP_IDX = 4'd13;

  typedef enum logic [3:0] {
    K_SUBS  = 4'd0,
    K_MOVS  = 4'd1,
    K_ADDS  = 4'd2,
    K_CMP   = 4'd3,
    K_ADD   = 4'd4,
    K_STR   = 4'd5,
    K_LDR   = 4'd6,
    K_SUBSP = 4'd7,
    K_BGT   = 4'd8,
    K_B     = 4'd9,
    K_UNDEF = 4'd10
  } kind_t;

  // decoded request
  typedef struct packed {
    kind_t             kind;
    logic [REG_AW-1:0] ra;     // first source
    logic [REG_AW-1:0] rb;     // second source
    logic [REG_AW-1:0] rd;     // destination
    logic              rw;     // writes a register
    logic [31:0]       imm;    // zero-extended immediate
    logic [10:0]       boff;   // branch offset, 11-bit signed
  } dec_t;

  function automatic dec_t decode(input logic [INSTR_W-1:0] w);
    dec_t d;
    d = '0;
    d.kind = K_UNDEF;
    if (w[15:13] == 3'd0 && w[12:9] == 4'd15) begin
      d.kind = K_SUBS; d.ra = {1'b0, w[5:3]}; d.rd = {1'b0, w[2:0]};
      d.imm = {29'd0, w[8:6]}; d.rw = 1'b1;
    end else if (w[15:11] == 5'b00100) begin
      d.kind = K_MOVS; d.rd = {1'b0, w[10:8]}; d.imm = {24'd0, w[7:0]}; d.rw = 1'b1;
    end else if (w[15:11] == 5'b00110) begin
      d.kind = K_ADDS; d.rd = {1'b0, w[10:8]}; d.ra = {1'b0, w[10:8]};
      d.imm = {24'd0, w[7:0]}; d.rw = 1'b1;
    end else if (w[15:6] == 10'b0100001010) begin
      d.kind = K_CMP; d.ra = {1'b0, w[2:0]}; d.rb = {1'b0, w[5:3]};
    end else if (w[15:10] == 6'b010001) begin
      d.kind = K_ADD; d.rd = {w[7], w[2:0]}; d.ra = {w[7], w[2:0]};
      d.rb = w[6:3]; d.rw = 1'b1;
    end else if (w[15:12] == 4'b0110) begin
      d.ra = {1'b0, w[5:3]}; d.rb = {1'b0, w[2:0]}; d.imm = {27'd0, w[10:6]};
      if (w[11]) begin
        d.kind = K_LDR; d.rd = {1'b0, w[2:0]}; d.rw = 1'b1;
      end else begin
        d.kind = K_STR;
      end
    end else if (w[15:7] == 9'b101100001) begin
      d.kind = K_SUBSP; d.ra = SP_IDX; d.rd = SP_IDX; d.imm = {25'd0, w[6:0]};
      d.rw = 1'b1;
    end else if (w[15:8] == 8'b11011100) begin
      d.kind = K_BGT; d.boff = {{3{w[7]}}, w[7:0]};
    end else if (w[15:11] == 5'b11100) begin
      d.kind = K_B; d.boff = w[10:0];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/thumb_subset_decode_execute.sv =====
// ----------------------------------------------------------------------------
// thumb_subset_decode_execute: Thumb-16 subset decode and execute core
// Executes SUBS, MOVS, ADDS, CMP, ADD hi, STR, LDR, SUB sp, BGT and B.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_instr   | request in
//  out     | out_valid, out_stall, out_*    | result out
//
// One instruction per cycle unless stalled; result is registered at accept.
// Stage 1 decodes, reads registers, executes and issues the data memory
// access; stage 2 (output register) merges LDR data from the RAM.
// Flags, PC and non-load register writes happen in stage 1. A load writes its
// register the cycle after accept; a request decoded in that cycle gets the
// RAM data forwarded. A store and a later load never share a cycle, so the
// RAM needs no bypass.
// Reset clears registers, flags and PC at once; data memory is cleared by a
// pass over all MEM_WORDS words after reset, during which in_stall is high.
// Stall: in_stall = out_valid & out_stall, or clearing in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module thumb_subset_decode_execute #(
  parameter int unsigned MEM_WORDS = 256,
  parameter int unsigned PC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_instr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_kind,
  output logic             out_reg_write,
  output logic [3:0]       out_reg_index,
  output logic signed [31:0] out_reg_value,
  output logic             out_mem_write,
  output logic [7:0]       out_mem_addr,
  output logic             out_zero_flag,
  output logic             out_neg_flag,
  output logic             out_branch_taken,
  output logic [15:0]      out_next_pc
);
  import tsde_pkg::*;

  localparam int unsigned MA_W = $clog2(MEM_WORDS);

  // clear pass
  logic [MA_W:0] clr_cnt_r, clr_cnt_nxt;
  logic          clearing;
  assign clearing = !clr_cnt_r[MA_W];

  logic accept;
  assign in_stall = clearing || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  dec_t d;
  assign d = decode(in_instr);

  logic [DATA_W-1:0] rf_da, rf_db, da, db;
  logic [DATA_W-1:0] rval;
  logic              rw;

  // load writeback, in the cycle after the load is accepted
  logic              ld_wb_r;
  logic [REG_AW-1:0] ridx_r;
  logic [DATA_W-1:0] ram_q;

  tsde_regfile u_rf (
    .clk(clk), .rst_n(rst_n), .we(accept && rw), .waddr(d.rd), .wdata(rval),
    .ld_we(ld_wb_r), .ld_waddr(ridx_r), .ld_wdata(ram_q),
    .ra(d.ra), .rb(d.rb), .da(rf_da), .db(rf_db)
  );

  // forward load data to the request being decoded
  assign da = (ld_wb_r && d.ra == ridx_r) ? ram_q : rf_da;
  assign db = (ld_wb_r && d.rb == ridx_r) ? ram_q : rf_db;

  logic z_r, n_r, z_nxt, n_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic taken;
  logic [DATA_W-1:0] addr_full;
  logic [MA_W-1:0]   maddr;

  assign addr_full = da + d.imm;
  assign maddr     = addr_full[MA_W-1:0];

  always_comb begin
    rval  = '0;
    rw    = d.rw && (d.kind != K_LDR);
    z_nxt = z_r;
    n_nxt = n_r;
    taken = 1'b0;
    unique case (d.kind)
      K_SUBS, K_SUBSP: rval = da - d.imm;
      K_MOVS:          rval = d.imm;
      K_ADDS:          rval = da + d.imm;
      K_ADD:           rval = da + db;
      K_CMP: begin
        z_nxt = (da == db);
        n_nxt = ($signed(da) < $signed(db));
      end
      K_BGT:   taken = !z_r && !n_r && (d.boff != '0);
      K_B:     taken = (d.boff != '0);
      default: ;
    endcase
    pc_nxt = taken ? pc_r + PC_BITS'({{(32-11){d.boff[10]}}, d.boff}) + PC_BITS'(2)
                   : pc_r + PC_BITS'(1);
  end

  tsde_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk),
    .we(clearing || (accept && d.kind == K_STR)),
    .waddr(clearing ? clr_cnt_r[MA_W-1:0] : maddr),
    .wdata(clearing ? '0 : db),
    .re(accept && d.kind == K_LDR),
    .raddr(maddr),
    .rdata(ram_q)
  );

  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      z_r <= 1'b0; n_r <= 1'b0; pc_r <= '0;
      out_valid <= 1'b0;
      ld_wb_r <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      ld_wb_r   <= accept && (d.kind == K_LDR);
      if (accept) begin
        z_r <= z_nxt; n_r <= n_nxt; pc_r <= pc_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage-2 payload
  kind_t             kind_r;
  logic              rw_r, mw_r, taken_r, z_o_r, n_o_r;
  logic [DATA_W-1:0] rval_r;
  logic [7:0]        maddr_r;
  logic [15:0]       npc_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= d.kind;
      rw_r    <= d.rw;
      ridx_r  <= d.rw ? d.rd : '0;
      rval_r  <= rval;
      mw_r    <= (d.kind == K_STR);
      maddr_r <= (d.kind == K_STR || d.kind == K_LDR) ? 8'(maddr) : 8'd0;
      z_o_r   <= z_nxt;
      n_o_r   <= n_nxt;
      taken_r <= taken;
      npc_r   <= 16'(pc_nxt);
    end
  end

  // RAM data holds while a load waits: no other load is accepted meanwhile
  assign out_kind         = kind_r;
  assign out_reg_write    = rw_r;
  assign out_reg_index    = ridx_r;
  assign out_reg_value    = (kind_r == K_LDR) ? ram_q : rval_r;
  assign out_mem_write    = mw_r;
  assign out_mem_addr     = maddr_r;
  assign out_zero_flag    = z_o_r;
  assign out_neg_flag     = n_o_r;
  assign out_branch_taken = taken_r;
  assign out_next_pc      = npc_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !accept) else $error("accept during clear");
  a_out_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid) else $error("result lost");
  a_flags_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && d.kind != K_CMP) |=> (z_r == $past(z_r) && n_r == $past(n_r)))
    else $error("flags changed outside CMP");
endmodule
`default_nettype wire

// ===== rtl/tsde_ram.sv =====
// ----------------------------------------------------------------------------
// tsde_ram: generic single-port-write, one-read synchronous RAM
// Registered read; rdata holds while re is low.
// ----------------------------------------------------------------------------
`default_nettype none
module tsde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tsde_regfile.sv =====
// ----------------------------------------------------------------------------
// tsde_regfile: 16 x 32 register file with reset-cleared contents
// Two combinational read ports, two write ports (main port wins on a clash).
// ----------------------------------------------------------------------------
`default_nettype none
module tsde_regfile (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        we,
  input  wire logic [tsde_pkg::REG_AW-1:0] waddr,
  input  wire logic [tsde_pkg::DATA_W-1:0] wdata,
  input  wire logic                        ld_we,
  input  wire logic [tsde_pkg::REG_AW-1:0] ld_waddr,
  input  wire logic [tsde_pkg::DATA_W-1:0] ld_wdata,
  input  wire logic [tsde_pkg::REG_AW-1:0] ra,
  input  wire logic [tsde_pkg::REG_AW-1:0] rb,
  output logic      [tsde_pkg::DATA_W-1:0] da,
  output logic      [tsde_pkg::DATA_W-1:0] db
);
  import tsde_pkg::*;
  logic [DATA_W-1:0] regs_r [NUM_REGS_C];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS_C; i++) regs_r[i] <= '0;
    end else begin
      // load data is older than the request in decode: that one wins
      if (ld_we && !(we && waddr == ld_waddr)) regs_r[ld_waddr] <= ld_wdata;
      if (we) regs_r[waddr] <= wdata;
    end
  end

  assign da = regs_r[ra];
  assign db = regs_r[rb];
endmodule
`default_nettype wire

// ===== tb/tb_thumb_subset_decode_execute.sv =====
// ----------------------------------------------------------------------------
// tb_thumb_subset_decode_execute: self-checking bench for the Thumb subset core
// Directed instruction table, then random programs, scored by a predictor that
// keeps its own registers, data memory, flags and program counter; fixed rows are typed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_thumb_subset_decode_execute;
  import tsde_pkg::*;

  localparam int MEM_DEPTH = 256;
  localparam int RANDOM_REQS = 1100;
  localparam int TAIL_REQS = 150;    // last requests: no idling on either side

  // Expected result of one request.
  typedef struct packed {
    kind_t       kind;
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [7:0]  mem_addr;
    logic        zero_flag;
    logic        neg_flag;
    logic        branch_taken;
    logic [15:0] next_pc;
  } exec_result_t;

  // One directed row: instruction, and a typed-in expectation when has_fixed.
  typedef struct {
    logic [15:0]  instr;
    bit           has_fixed;
    exec_result_t fixed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_instr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_kind;
  logic        out_reg_write;
  logic [3:0]  out_reg_index;
  logic signed [31:0] out_reg_value;
  logic        out_mem_write;
  logic [7:0]  out_mem_addr;
  logic        out_zero_flag;
  logic        out_neg_flag;
  logic        out_branch_taken;
  logic [15:0] out_next_pc;

  // Shadow architectural state.
  logic [31:0] arch_regs [16];
  logic [31:0] arch_mem [MEM_DEPTH];
  logic        arch_z, arch_n;
  logic [15:0] arch_pc;

  exec_result_t pending_results[$];
  int  errors = 0;
  bit  quiet_tail = 1'b0;     // set for the last part of the run
  bit  long_hold = 1'b0;      // receiver holds off for a long stretch

  always #5 clk = ~clk;

  thumb_subset_decode_execute DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_instr(in_instr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_reg_write(out_reg_write),
    .out_reg_index(out_reg_index), .out_reg_value(out_reg_value),
    .out_mem_write(out_mem_write), .out_mem_addr(out_mem_addr),
    .out_zero_flag(out_zero_flag), .out_neg_flag(out_neg_flag),
    .out_branch_taken(out_branch_taken), .out_next_pc(out_next_pc)
  );

  // Executes one instruction on the shadow state and returns what it reports.
  function automatic exec_result_t execute_instr(input logic [15:0] w);
    exec_result_t r;
    logic [31:0] a;
    logic [15:0] offs;
    logic [3:0]  ridx;
    r = '0;
    r.kind = K_UNDEF;
    offs = '0;
    if (w[15:13] == 3'd0 && w[12:9] == 4'd15) begin
      r.kind = K_SUBS; r.reg_write = 1; r.reg_index = {1'b0, w[2:0]};
      r.reg_value = arch_regs[w[5:3]] - 32'(w[8:6]);
    end else if (w[15:11] == 5'b00100) begin
      r.kind = K_MOVS; r.reg_write = 1; r.reg_index = {1'b0, w[10:8]};
      r.reg_value = 32'(w[7:0]);
    end else if (w[15:11] == 5'b00110) begin
      r.kind = K_ADDS; r.reg_write = 1; r.reg_index = {1'b0, w[10:8]};
      r.reg_value = arch_regs[w[10:8]] + 32'(w[7:0]);
    end else if (w[15:6] == 10'b0100001010) begin
      r.kind = K_CMP;
      arch_z = (arch_regs[w[2:0]] == arch_regs[w[5:3]]);
      arch_n = ($signed(arch_regs[w[2:0]]) < $signed(arch_regs[w[5:3]]));
    end else if (w[15:10] == 6'b010001) begin
      ridx = {w[7], w[2:0]};
      r.kind = K_ADD; r.reg_write = 1; r.reg_index = ridx;
      r.reg_value = arch_regs[ridx] + arch_regs[w[6:3]];
    end else if (w[15:12] == 4'b0110) begin
      a = (arch_regs[w[5:3]] + 32'(w[10:6])) % MEM_DEPTH;
      r.mem_addr = a[7:0];
      if (!w[11]) begin
        r.kind = K_STR; r.mem_write = 1;
        arch_mem[a] = arch_regs[w[2:0]];
      end else begin
        r.kind = K_LDR; r.reg_write = 1; r.reg_index = {1'b0, w[2:0]};
        r.reg_value = arch_mem[a];
      end
    end else if (w[15:7] == 9'b101100001) begin
      r.kind = K_SUBSP; r.reg_write = 1; r.reg_index = SP_IDX;
      r.reg_value = arch_regs[SP_IDX] - 32'(w[6:0]);
    end else if (w[15:8] == 8'b11011100) begin
      r.kind = K_BGT;
      offs = {{8{w[7]}}, w[7:0]};
      r.branch_taken = !arch_z && !arch_n && w[7:0] != 0;
    end else if (w[15:11] == 5'b11100) begin
      r.kind = K_B;
      offs = {{5{w[10]}}, w[10:0]};
      r.branch_taken = w[10:0] != 0;
    end
    if (r.reg_write) arch_regs[r.reg_index] = r.reg_value;
    arch_pc = r.branch_taken ? arch_pc + offs + 16'd2 : arch_pc + 16'd1;
    r.zero_flag = arch_z;
    r.neg_flag = arch_n;
    r.next_pc = arch_pc;
    return r;
  endfunction

  // Random instruction: mostly well-formed encodings, some raw noise.
  function automatic logic [15:0] random_instr();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 11))
      0: return {7'b0001111, r[8:0]};
      1: return {5'b00100, r[10:0]};
      2: return {5'b00110, r[10:0]};
      3: return {10'b0100001010, r[5:0]};
      4: return {6'b010001, r[9:0]};
      5: return {5'b01100, r[10:0]};
      6: return {5'b01101, r[10:0]};
      7: return {9'b101100001, r[6:0]};
      8: return {8'b11011100, r[7:0]};
      9: return {5'b11100, r[10:0]};
      default: return r;
    endcase
  endfunction

  // Send one request: idle bursts, then hold until accepted.
  task automatic send_request(input logic [15:0] w);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instr <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instr(w));
  endtask

  function automatic exec_result_t mk(kind_t k, logic rw, logic [3:0] ri, logic [31:0] rv,
                                      logic mw, logic [7:0] ma, logic z, logic n,
                                      logic bt, logic [15:0] pc);
    exec_result_t r;
    r = '{k, rw, ri, rv, mw, ma, z, n, bt, pc};
    return r;
  endfunction

  // Stimulus
  initial begin
    dir_row_t rows[$];
    int i;
    for (i = 0; i < 16; i++) arch_regs[i] = '0;
    for (i = 0; i < MEM_DEPTH; i++) arch_mem[i] = '0;
    arch_z = 0; arch_n = 0; arch_pc = '0;

    // Fixed rows straight after reset; others go through the predictor.
    rows.push_back('{16'h0000, 1, mk(K_UNDEF, 0, 0, 0, 0, 0, 0, 0, 0, 16'd1)});
    rows.push_back('{16'hFFFF, 1, mk(K_UNDEF, 0, 0, 0, 0, 0, 0, 0, 0, 16'd2)});
    rows.push_back('{16'h20FF, 1, mk(K_MOVS, 1, 0, 32'd255, 0, 0, 0, 0, 0, 16'd3)});
    rows.push_back('{16'h1FC0, 1, mk(K_SUBS, 1, 0, 32'd248, 0, 0, 0, 0, 0, 16'd4)});
    rows.push_back('{16'h37FF, 0, '0});                  // ADDS r7, #255
    rows.push_back('{16'h4287, 0, '0});                  // CMP r7, r0: Z and N clear
    rows.push_back('{16'h42BF, 0, '0});                  // CMP equal
    rows.push_back('{16'h4238, 0, '0});                  // not a CMP encoding: decodes as undefined
    rows.push_back('{16'h47FF, 0, '0});                  // ADD r15, r15, bits 9..8 set
    rows.push_back('{16'h4478, 0, '0});                  // ADD r0, r15
    rows.push_back('{16'h6007, 0, '0});                  // STR r7, [r0]
    rows.push_back('{16'h6FFE, 0, '0});                  // LDR imm5 max: address wraps
    rows.push_back('{16'h6807, 0, '0});                  // LDR back from the STR address
    rows.push_back('{16'h6FFD, 0, '0});
    rows.push_back('{16'hB0FF, 0, '0});                  // SUB sp, #127
    rows.push_back('{16'hB080, 0, '0});                  // SUB sp, #0
    rows.push_back('{16'h4280, 0, '0});                  // CMP r0, r0: Z set
    rows.push_back('{16'hDC05, 0, '0});                  // BGT not taken
    rows.push_back('{16'h2101, 0, '0});
    rows.push_back('{16'h4288, 0, '0});                  // CMP r0, r1 -> Z,N clear
    rows.push_back('{16'hDC80, 0, '0});                  // BGT most negative
    rows.push_back('{16'hDC00, 0, '0});                  // BGT zero offset
    rows.push_back('{16'hE3FF, 0, '0});                  // B most positive
    rows.push_back('{16'hE400, 0, '0});                  // B most negative
    rows.push_back('{16'hE000, 0, '0});                  // B zero offset

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      send_request(rows[k].instr);
      if (rows[k].has_fixed) pending_results[$] = rows[k].fixed;
    end
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i == 200) long_hold = 1'b1;
      if (i == RANDOM_REQS - TAIL_REQS) quiet_tail = 1'b1;
      send_request(random_instr());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb_thumb_subset_decode_execute OK");
    else $display("tb_thumb_subset_decode_execute NOT OK");
    $finish;
  end

  // Receiver stall pattern, with one long hold-off so the core backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Scoreboard: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    exec_result_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind_t'(out_kind), out_reg_write, out_reg_index, out_reg_value,
              out_mem_write, out_mem_addr, out_zero_flag, out_neg_flag,
              out_branch_taken, out_next_pc};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb_thumb_subset_decode_execute NOT OK");
    $finish;
  end

endmodule
